// ----- rtl/core/irptc_pkg.sv -----
package irptc_pkg;

	// build defaults for the top-level parameters
	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int TIMER_BITS_DEF   = 16;

	// fixed field widths
	localparam int OP_W       = 2;
	localparam int IDX_W      = 6;
	localparam int RWIDTH_W   = 16;
	localparam int RCOUNT_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TIMEOUT_W  = 16;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RX_ACTIVE_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TX_ACTIVE_LOW = 2'd2;

	// configuration reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd10000;
	localparam logic                 RX_ACTIVE_LOW_RST = 1'b1;
	localparam logic                 TX_ACTIVE_LOW_RST = 1'b1;

	// saturation value of the reported count
	localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = '1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK = 2'd0,
		OP_ARM  = 2'd1,
		OP_TX   = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef struct packed {
		op_t              kind;
		logic             rx_level;
		logic [IDX_W-1:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic                 rx_active_low;
		logic                 tx_active_low;
	} cfg_t;

endpackage

// ----- rtl/core/irptc_if.sv -----
interface irptc_in_if import irptc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic             rx_level;
	logic [IDX_W-1:0] read_index;

	modport source (output valid, output op, output rx_level, output read_index, input ready);
	modport sink   (input valid, input op, input rx_level, input read_index, output ready);
endinterface

interface irptc_out_if import irptc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                tx_level;
	logic                received;
	logic [RCOUNT_W-1:0] received_count;
	logic                transmit_busy;
	logic                transmitted;
	logic [RWIDTH_W-1:0] read_width;
	logic                status;

	modport source (
		output valid, output tx_level, output received, output received_count,
		output transmit_busy, output transmitted, output read_width, output status,
		input ready
	);
	modport sink (
		input valid, input tx_level, input received, input received_count,
		input transmit_busy, input transmitted, input read_width, input status,
		output ready
	);
endinterface

// ----- rtl/core/ir_pulse_train_capture_replay.sv -----
// channel   dir  handshake      payload
// in_ch     in   valid/ready    op, rx_level, read_index
// out_ch    out  valid/ready    tx_level, received, received_count, transmit_busy,
//                               transmitted, read_width, status
// cfg       in   cfg_write      cfg_index, cfg_data (no read-back)
//
// one item per clock sustained while the output side is ready; an item's result is
// registered through the queue write at accept, the memory read and the execute into
// the output register
// the rate is set by the execute stage and the two-port width store
// arst_n clears all control state; the width store itself is not cleared
// a stalled output holds its result while the four-entry queue keeps taking items
// until it fills, then input ready drops
module ir_pulse_train_capture_replay import irptc_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	irptc_in_if.sink              in_ch,
	irptc_out_if.source           out_ch
);

	// configuration registers
	cfg_t cfg_q;

	// queue head handed from the front to the back
	cmd_t head;
	logic head_valid;
	logic pop;

	// register writes land directly; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
			cfg_q.rx_active_low <= RX_ACTIVE_LOW_RST;
			cfg_q.tx_active_low <= TX_ACTIVE_LOW_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= TIMEOUT_W'(cfg_data);
				REG_RX_ACTIVE_LOW: cfg_q.rx_active_low <= cfg_data[0];
				REG_TX_ACTIVE_LOW: cfg_q.tx_active_low <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: takes items, decodes the op and queues them
	irptc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back: width store, timers, capture and replay, output register
	irptc_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.TIMER_BITS   (TIMER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// ----- rtl/core/irptc_front.sv -----
module irptc_front import irptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	irptc_in_if.sink   in_ch,
	output cmd_t       head,
	output logic       head_valid,
	input  logic       pop
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           queue_q [QUEUE_DEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           do_pop;
	cmd_t           cmd_in;

	// classify the incoming item
	always_comb begin
		cmd_in.kind       = op_t'(in_ch.op);
		cmd_in.rx_level   = in_ch.rx_level;
		cmd_in.read_index = in_ch.read_index;
	end

	assign in_ch.ready = (cnt_q != QCW'(QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign head_valid  = (cnt_q != '0);
	assign do_pop      = pop && head_valid;
	assign head        = queue_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QAW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QAW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= cmd_in;
		end
	end

endmodule

// ----- rtl/core/irptc_back.sv -----
module irptc_back import irptc_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  cmd_t         head,
	input  logic         head_valid,
	output logic         pop,
	irptc_out_if.source  out_ch
);

	localparam int TB = TIMER_BITS;
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(BUFFER_DEPTH + 1);

	// width store, two registered read ports
	logic [TB-1:0] mem_q [BUFFER_DEPTH];

	// execute stage
	cmd_t          cmd_s2;
	logic          valid_s2;
	logic [TB-1:0] rd1_s2;
	logic [TB-1:0] rd2_q;

	// block state
	logic [TB-1:0] timer_q, timer_d;
	logic [TB-1:0] last_edge_q, last_edge_d;
	logic [TB-1:0] to_deadline_q, to_deadline_d;
	logic          prev_rx_q, prev_rx_d;
	logic          expect_rise_q, expect_rise_d;
	logic          cap_en_q, cap_en_d;
	logic          to_en_q, to_en_d;
	logic          storing_q, storing_d;
	logic [CW-1:0] count_q, count_d;
	logic          rcv_q, rcv_d;
	logic [CW-1:0] ri_q, ri_d;
	logic [TB-1:0] rp_deadline_q, rp_deadline_d;
	logic          rp_active_q, rp_active_d;
	logic          rp_done_q, rp_done_d;
	logic          out_level_q, out_level_d;

	// output register
	logic                out_valid_q;
	logic                o_tx_q, o_rcv_q, o_busy_q, o_done_q, o_st_q;
	logic [RCOUNT_W-1:0] o_cnt_q;
	logic [RWIDTH_W-1:0] o_rw_q;

	logic                fire;
	logic                out_can;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [TB-1:0]       wdata;
	logic [AW-1:0]       raddr1;
	logic [AW-1:0]       raddr2;
	logic [CW-1:0]       ri_nxt;
	logic [TB-1:0]       t1;
	logic                rx_edge;
	logic [TB-1:0]       rp_width;
	logic [RWIDTH_W-1:0] rw;
	logic                st;
	logic [RCOUNT_W-1:0] rc;
	logic [7:0]          cnt_ext;

	assign out_can = !out_valid_q || out_ch.ready;
	assign fire    = valid_s2 && out_can;
	assign pop     = head_valid && (!valid_s2 || fire);

	// read port one serves the popped item
	always_comb begin
		case (head.kind)
			OP_TX:   raddr1 = '0;
			default: raddr1 = AW'(head.read_index);
		endcase
	end

	// read port two tracks the entry at the next replay index
	assign ri_nxt = fire ? ri_d : ri_q;
	assign raddr2 = ri_nxt[AW-1:0];

	always_ff @(posedge clk) begin
		if (fire && we) begin
			mem_q[waddr] <= wdata;
		end
		if (pop) begin
			rd1_s2 <= (fire && we && waddr == raddr1) ? wdata : mem_q[raddr1];
		end
		rd2_q <= (fire && we && waddr == raddr2) ? wdata : mem_q[raddr2];
	end

	// execute
	always_comb begin
		timer_d       = timer_q;
		last_edge_d   = last_edge_q;
		to_deadline_d = to_deadline_q;
		prev_rx_d     = prev_rx_q;
		expect_rise_d = expect_rise_q;
		cap_en_d      = cap_en_q;
		to_en_d       = to_en_q;
		storing_d     = storing_q;
		count_d       = count_q;
		rcv_d         = rcv_q;
		ri_d          = ri_q;
		rp_deadline_d = rp_deadline_q;
		rp_active_d   = rp_active_q;
		rp_done_d     = rp_done_q;
		out_level_d   = out_level_q;
		t1            = timer_q + TB'(1);
		we            = 1'b0;
		waddr         = count_q[AW-1:0];
		wdata         = t1 - last_edge_q;
		rx_edge       = expect_rise_q ? (!prev_rx_q && cmd_s2.rx_level)
		                              : (prev_rx_q && !cmd_s2.rx_level);
		rw            = '0;
		st            = 1'b0;
		rp_width      = rd2_q;
		case (cmd_s2.kind)
			OP_TICK: begin
				timer_d = t1;
				if (to_en_q && t1 == to_deadline_q) begin
					if (count_q != '0) begin
						cap_en_d = 1'b0;
						to_en_d  = 1'b0;
						rcv_d    = 1'b1;
					end
					storing_d = 1'b0;
				end
				prev_rx_d = cmd_s2.rx_level;
				if (cap_en_d && rx_edge) begin
					expect_rise_d = !expect_rise_q;
					last_edge_d   = t1;
					to_deadline_d = t1 + TB'(cfg.timeout_ticks);
					if (storing_d) begin
						if (count_q < CW'(BUFFER_DEPTH)) begin
							we      = 1'b1;
							count_d = count_q + CW'(1);
						end
						if (count_d >= CW'(BUFFER_DEPTH)) begin
							cap_en_d = 1'b0;
						end
					end else begin
						storing_d = 1'b1;
						to_en_d   = 1'b1;
					end
				end
				// a width written on this tick may be the one replay needs now
				if (we && waddr == ri_q[AW-1:0]) begin
					rp_width = wdata;
				end
				if (rp_active_q && t1 == rp_deadline_q) begin
					out_level_d = !out_level_q;
					if (ri_q < count_d && ri_q < CW'(BUFFER_DEPTH)) begin
						rp_deadline_d = rp_deadline_q + rp_width;
						ri_d          = ri_q + CW'(1);
					end else begin
						rp_active_d = 1'b0;
						rp_done_d   = 1'b1;
					end
				end
			end
			OP_ARM: begin
				count_d       = '0;
				rcv_d         = 1'b0;
				storing_d     = 1'b0;
				to_en_d       = 1'b0;
				expect_rise_d = !cfg.rx_active_low;
				cap_en_d      = 1'b1;
			end
			OP_TX: begin
				rp_done_d = 1'b0;
				if (count_q == '0) begin
					st = 1'b1;
				end else begin
					ri_d          = CW'(1);
					rp_deadline_d = timer_q + rd1_s2;
					out_level_d   = !cfg.tx_active_low;
					rp_active_d   = 1'b1;
				end
			end
			OP_READ: begin
				if (9'(cmd_s2.read_index) < 9'(count_q)
				    && 9'(cmd_s2.read_index) < 9'(BUFFER_DEPTH)) begin
					rw = RWIDTH_W'(rd1_s2);
				end
			end
			default: begin
			end
		endcase
		cnt_ext = rcv_d ? 8'(count_d) : 8'd0;
		rc      = (cnt_ext > 8'(RCOUNT_MAX)) ? RCOUNT_MAX : cnt_ext[RCOUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			timer_q       <= '0;
			last_edge_q   <= '0;
			to_deadline_q <= '0;
			prev_rx_q     <= 1'b1;
			expect_rise_q <= 1'b0;
			cap_en_q      <= 1'b0;
			to_en_q       <= 1'b0;
			storing_q     <= 1'b0;
			count_q       <= '0;
			rcv_q         <= 1'b0;
			ri_q          <= '0;
			rp_deadline_q <= '0;
			rp_active_q   <= 1'b0;
			rp_done_q     <= 1'b0;
			out_level_q   <= TX_ACTIVE_LOW_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				timer_q       <= timer_d;
				last_edge_q   <= last_edge_d;
				to_deadline_q <= to_deadline_d;
				prev_rx_q     <= prev_rx_d;
				expect_rise_q <= expect_rise_d;
				cap_en_q      <= cap_en_d;
				to_en_q       <= to_en_d;
				storing_q     <= storing_d;
				count_q       <= count_d;
				rcv_q         <= rcv_d;
				ri_q          <= ri_d;
				rp_deadline_q <= rp_deadline_d;
				rp_active_q   <= rp_active_d;
				rp_done_q     <= rp_done_d;
				out_level_q   <= out_level_d;
				out_valid_q   <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s2 <= head;
		end
		if (fire) begin
			o_tx_q   <= out_level_d;
			o_rcv_q  <= rcv_d;
			o_cnt_q  <= rc;
			o_busy_q <= rp_active_d;
			o_done_q <= rp_done_d;
			o_rw_q   <= rw;
			o_st_q   <= st;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.tx_level       = o_tx_q;
	assign out_ch.received       = o_rcv_q;
	assign out_ch.received_count = o_cnt_q;
	assign out_ch.transmit_busy  = o_busy_q;
	assign out_ch.transmitted    = o_done_q;
	assign out_ch.read_width     = o_rw_q;
	assign out_ch.status         = o_st_q;

endmodule

// ----- tb/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import irptc_pkg::*;

	localparam int DEPTH       = BUFFER_DEPTH_DEF;
	localparam int TBITS       = TIMER_BITS_DEF;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int RAND_ITEMS  = 1000;
	localparam int RAND_PHASES = 6;
	localparam int SETTLE      = 8;   // settle margin past the three pipeline stages

	// one result item as seen on out_ch
	typedef struct packed {
		logic                tx_level;
		logic                received;
		logic [RCOUNT_W-1:0] received_count;
		logic                transmit_busy;
		logic                transmitted;
		logic [RWIDTH_W-1:0] read_width;
		logic                status;
	} ir_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	irptc_in_if  in_ch ();
	irptc_out_if out_ch ();

	ir_pulse_train_capture_replay u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// capture/replay state as the block should hold it
	// ---------------------------------------------------------------
	logic [TBITS-1:0]     tmr         = '0;
	logic [TBITS-1:0]     last_edge_t = '0;
	logic [TBITS-1:0]     to_due      = '0;
	logic [TBITS-1:0]     rp_due      = '0;
	logic                 prev_lvl    = 1'b1;   // pin idles high
	logic                 want_rise   = 1'b0;
	logic                 cap_on      = 1'b0;
	logic                 to_on       = 1'b0;
	logic                 storing_on  = 1'b0;
	logic                 rcv         = 1'b0;
	logic                 rp_on       = 1'b0;
	logic                 rp_fin      = 1'b0;
	logic                 tx_lvl      = TX_ACTIVE_LOW_RST;
	logic [RCOUNT_W-1:0]  n_widths    = '0;
	logic [RCOUNT_W-1:0]  rp_idx      = '0;
	logic [TBITS-1:0]     widths [DEPTH];

	// register copies, kept in step with every write
	logic [TIMEOUT_W-1:0] cfg_to    = TIMEOUT_TICKS_RST;
	logic                 cfg_rx_al = RX_ACTIVE_LOW_RST;
	logic                 cfg_tx_al = TX_ACTIVE_LOW_RST;

	// bookkeeping
	cmd_t       cmd_backlog[$];
	ir_result_t expected_outputs[$];
	logic       live       = 1'b0;
	logic       item_taken = 1'b0;
	logic       calm       = 1'b0;   // no idling on either side
	logic       gen_level  = 1'b1;   // pin level of the last queued tick
	int         pushed       = 0;
	int         results_seen = 0;
	int         n_errors     = 0;
	int         cycles       = 0;

	// advance the model by one item and return the outputs it should show
	task automatic replay_model_step(input cmd_t c, output ir_result_t r);
		logic hit;
		r = '0;
		case (c.kind)
			OP_TICK: begin
				tmr = tmr + 1'b1;
				// timeout is checked before the edge on the same tick
				if (to_on && tmr == to_due) begin
					if (n_widths != 0) begin
						cap_on = 1'b0;
						to_on  = 1'b0;
						rcv    = 1'b1;
					end
					storing_on = 1'b0;
				end
				hit = want_rise ? (!prev_lvl && c.rx_level) : (prev_lvl && !c.rx_level);
				prev_lvl = c.rx_level;
				if (cap_on && hit) begin
					want_rise = !want_rise;
					if (storing_on) begin
						if (n_widths < DEPTH) begin
							widths[n_widths] = tmr - last_edge_t;
							n_widths++;
						end
						// buffer full: no more edges, pending timeout still ends the train
						if (n_widths >= DEPTH)
							cap_on = 1'b0;
					end else begin
						// first edge of a train only opens storage
						storing_on = 1'b1;
						to_on      = 1'b1;
					end
					last_edge_t = tmr;
					to_due      = tmr + cfg_to;
				end
				if (rp_on && tmr == rp_due) begin
					tx_lvl = !tx_lvl;
					if (rp_idx < n_widths) begin
						rp_due = rp_due + widths[rp_idx];
						rp_idx++;
					end else begin
						rp_on  = 1'b0;
						rp_fin = 1'b1;
					end
				end
			end
			OP_ARM: begin
				// an active replay keeps running against the new count
				n_widths   = '0;
				rcv        = 1'b0;
				storing_on = 1'b0;
				to_on      = 1'b0;
				want_rise  = !cfg_rx_al;
				cap_on     = 1'b1;
			end
			OP_TX: begin
				rp_fin = 1'b0;
				if (n_widths == 0) begin
					r.status = 1'b1;
				end else begin
					rp_idx = RCOUNT_W'(1);
					rp_due = tmr + widths[0];
					tx_lvl = !cfg_tx_al;
					rp_on  = 1'b1;
				end
			end
			OP_READ: begin
				if (c.read_index < n_widths)
					r.read_width = widths[c.read_index];
			end
		endcase
		r.tx_level       = tx_lvl;
		r.received       = rcv;
		r.received_count = rcv ? n_widths : '0;
		r.transmit_busy  = rp_on;
		r.transmitted    = rp_fin;
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
		n_errors++;
	endtask

	// ---------------------------------------------------------------
	// rising edge: check result items, then predict on accepted input items
	// ---------------------------------------------------------------
	always @(posedge clk) begin : sample
		ir_result_t w;
		cmd_t       c;
		live       <= arst_n;
		item_taken <= live && in_ch.valid && in_ch.ready;
		if (live && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_outputs.size() == 0) begin
				report_mismatch("result items with nothing pending", 1, 0);
			end else begin
				w = expected_outputs.pop_front();
				if (out_ch.tx_level !== w.tx_level)
					report_mismatch("tx_level", out_ch.tx_level, w.tx_level);
				if (out_ch.received !== w.received)
					report_mismatch("received", out_ch.received, w.received);
				if (out_ch.received_count !== w.received_count)
					report_mismatch("received_count", out_ch.received_count, w.received_count);
				if (out_ch.transmit_busy !== w.transmit_busy)
					report_mismatch("transmit_busy", out_ch.transmit_busy, w.transmit_busy);
				if (out_ch.transmitted !== w.transmitted)
					report_mismatch("transmitted", out_ch.transmitted, w.transmitted);
				if (out_ch.read_width !== w.read_width)
					report_mismatch("read_width", out_ch.read_width, w.read_width);
				if (out_ch.status !== w.status)
					report_mismatch("status", out_ch.status, w.status);
			end
		end
		if (live && in_ch.valid && in_ch.ready) begin
			c.kind       = op_t'(in_ch.op);
			c.rx_level   = in_ch.rx_level;
			c.read_index = in_ch.read_index;
			replay_model_step(c, w);
			expected_outputs.push_back(w);
		end
	end

	// ---------------------------------------------------------------
	// input driver: falling edge, random idle bursts between items
	// ---------------------------------------------------------------
	int in_gap  = 0;
	int in_busy = 2;

	always @(negedge clk) begin : drive_in
		cmd_t nxt;
		if (live) begin
			if (!in_ch.valid || item_taken) begin
				if (in_gap > 0) begin
					in_ch.valid <= 1'b0;
					in_gap--;
				end else if (cmd_backlog.size() != 0 && !calm
						&& $urandom_range(0, 15) < in_busy) begin
					// idle burst
					in_ch.valid <= 1'b0;
					in_gap = $urandom_range(0, 18);
				end else if (cmd_backlog.size() != 0) begin
					nxt = cmd_backlog.pop_front();
					in_ch.valid      <= 1'b1;
					in_ch.op         <= nxt.kind;
					in_ch.rx_level   <= nxt.rx_level;
					in_ch.read_index <= nxt.read_index;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			// drift between busy and quiet stretches
			if ($urandom_range(0, 199) == 0)
				in_busy = $urandom_range(0, 4);
		end
	end

	// ---------------------------------------------------------------
	// output ready: random stalls, plus one long hold-off so the queue fills
	// ---------------------------------------------------------------
	int   stall_left = 0;
	int   hold_left  = 0;
	int   out_busy   = 2;
	logic held_once  = 1'b0;

	always @(negedge clk) begin
		if (live) begin
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (!held_once && results_seen >= 200 && cmd_backlog.size() > 20) begin
				held_once = 1'b1;
				hold_left = 399;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 15) < out_busy) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				out_ch.ready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0)
				out_busy = $urandom_range(0, 4);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------
	task automatic push_cmd(input op_t k, input int lvl, input int idx);
		cmd_t c;
		c.kind       = k;
		c.rx_level   = lvl[0];
		c.read_index = IDX_W'(idx);
		cmd_backlog.push_back(c);
		if (k == OP_TICK)
			gen_level = lvl[0];
		pushed++;
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_cmd(OP_TICK, int'(gen_level), $urandom_range(0, 63));
	endtask

	// arm, then edges spaced 1..gmax ticks apart, then wait out the timeout;
	// span is the replay length of the widths that should be stored
	task automatic push_train(input int edges, input int gmax, input logic wrong_start,
			output int span);
		int g;
		span = 0;
		// starting at the active level makes the first transition the wrong polarity
		gen_level = wrong_start ? !cfg_rx_al : cfg_rx_al;
		push_ticks($urandom_range(1, 3));
		push_cmd(OP_ARM, $urandom_range(0, 1), $urandom_range(0, 63));
		push_ticks($urandom_range(0, 3));
		for (int e = 0; e < edges; e++) begin
			gen_level = !gen_level;
			g = $urandom_range(1, gmax);
			if (e < edges - 1 && e < DEPTH)
				span += g;
			push_ticks(g);
		end
		push_ticks(cfg_to + 2);
	endtask

	// reads, then a replay with an occasional interruption
	task automatic play_back(input int span);
		int mid;
		repeat ($urandom_range(1, 4))
			push_cmd(OP_READ, $urandom_range(0, 1),
				$urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 12));
		push_cmd(OP_TX, $urandom_range(0, 1), $urandom_range(0, 63));
		mid = $urandom_range(0, span + 3);
		push_ticks(mid);
		// restart, re-arm or read in the middle of a replay
		if ($urandom_range(0, 3) == 0)
			push_cmd(op_t'($urandom_range(OP_ARM, OP_READ)), $urandom_range(0, 1),
				$urandom_range(0, 63));
		push_ticks(span + 3 - mid);
	endtask

	task automatic random_sequence();
		int pick;
		int span;
		int gmax;
		pick = $urandom_range(0, 9);
		gmax = (cfg_to - 1 < 8) ? cfg_to - 1 : 8;
		if (pick <= 5) begin
			// clean train, now and then long enough to fill the buffer
			push_train(($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12),
				$urandom_range(1, gmax), 1'b0, span);
			play_back(span);
		end else if (pick <= 7) begin
			// gaps may exceed the timeout, start may be the wrong polarity
			push_train($urandom_range(1, 10), cfg_to + 3, $urandom_range(0, 1), span);
			play_back(span);
		end else begin
			repeat ($urandom_range(3, 15))
				push_cmd(op_t'($urandom_range(OP_TICK, OP_READ)), $urandom_range(0, 1),
					$urandom_range(0, 63));
		end
	endtask

	// wait until every item is in and every result is out
	task automatic drain();
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || in_ch.valid || expected_outputs.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = CFG_DATA_W'(data);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_config(input int tmo, input logic rx_al, input logic tx_al);
		write_reg(REG_TIMEOUT_TICKS, tmo);
		write_reg(REG_RX_ACTIVE_LOW, rx_al);
		write_reg(REG_TX_ACTIVE_LOW, tx_al);
		cfg_to    = TIMEOUT_W'(tmo);
		cfg_rx_al = rx_al;
		cfg_tx_al = tx_al;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		int span;
		int start;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = REG_TIMEOUT_TICKS;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.op         = OP_TICK;
		in_ch.rx_level   = 1'b1;
		in_ch.read_index = '0;
		out_ch.ready     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset settings, both sides active low
		push_cmd(OP_READ, 1'b0, 0);            // nothing stored yet
		push_cmd(OP_READ, 1'b1, 63);
		push_cmd(OP_TX, 1'b0, 0);              // empty buffer gives status
		push_cmd(OP_TICK, 1'b0, 0);            // edge while capture is off
		push_cmd(OP_TICK, 1'b1, 0);
		drain();

		// short timeout, same polarities
		set_config(40, 1'b1, 1'b1);
		push_train(5, 30, 1'b0, span);
		for (int i = 0; i <= 5; i++)
			push_cmd(OP_READ, 1'b0, i);         // entries past the count read as zero
		push_cmd(OP_TX, 1'b1, 0);
		push_ticks(span / 2);
		push_cmd(OP_TX, 1'b0, 0);              // restart from the first width
		push_ticks(span / 2);
		push_cmd(OP_ARM, 1'b0, 0);             // replay runs on against an empty count
		push_ticks(span + 3);
		push_cmd(OP_TX, 1'b0, 0);
		push_ticks(3);
		drain();

		// timeout of one tick: every edge is a first edge, nothing is stored
		set_config(1, 1'b0, 1'b0);
		push_train(6, 3, 1'b0, span);
		push_cmd(OP_READ, 1'b0, 0);
		push_cmd(OP_TX, 1'b1, 63);
		push_ticks(4);
		drain();

		// longer timeout, long widths
		set_config(100, 1'b1, 1'b1);
		push_train(3, 90, 1'b0, span);
		play_back(span);
		drain();

		// back-to-back edges overflow the buffer
		set_config(2, 1'b0, 1'b1);
		push_train(70, 1, 1'b0, span);
		push_cmd(OP_READ, 1'b1, 63);
		play_back(span);
		drain();

		// random trains, replays and noise over several settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_config($urandom_range(2, 40), $urandom_range(0, 1), $urandom_range(0, 1));
			if (ph == RAND_PHASES - 1)
				calm = 1'b1;
			start = pushed;
			while (pushed - start < RAND_ITEMS / RAND_PHASES)
				random_sequence();
			drain();
		end

		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/irptc_pkg.sv
rtl/core/irptc_if.sv
rtl/core/irptc_front.sv
rtl/core/irptc_back.sv
rtl/core/ir_pulse_train_capture_replay.sv
tb/tb.sv
